/* rtl/core/stop_and_wait_arq_sender_unit_defines.svh */
// assertion macros for the stop-and-wait arq sender
// each macro samples on clk_i and is quiet while rst_ni is low
`ifndef STOP_AND_WAIT_ARQ_SENDER_UNIT_DEFINES_SVH
`define STOP_AND_WAIT_ARQ_SENDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SAWARQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sawarq assertion failed");
`define SAWARQ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sawarq forbidden condition seen");
`else
`define SAWARQ_ASSERT(lbl, prop)
`define SAWARQ_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/core/sawarq_pkg.sv */
`default_nettype none

package sawarq_pkg;

  // configuration port
  localparam int unsigned CFG_DW    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 2'd3;

  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] BACKOFF_BASE_RST = 16'd100;
  localparam logic [15:0] BACKOFF_MAX_RST  = 16'd2000;
  localparam logic [3:0]  MAX_RETRIES_RST  = 4'd3;

  // request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SEND = 2'd1;
  localparam logic [1:0] REQ_ACK  = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FRAME     = 2'd0;
  localparam logic [1:0] KIND_DELIVERED = 2'd1;
  localparam logic [1:0] KIND_FAILED    = 2'd2;
  localparam logic [1:0] KIND_REJECTED  = 2'd3;

  // protocol phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_BACKOFF = 2'd2;

  localparam logic [7:0] DATA_TYPE = 8'h00;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] seq;
    logic [7:0] send_len;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_byte;
    logic        last;
    logic [3:0]  attempt;
    logic [31:0] sent_count;
    logic [31:0] acked_count;
    logic [31:0] failed_count;
    logic [31:0] retry_count;
  } res_item_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       store_wr;
    logic       start_send;
    logic       ack_done;
    logic       tick_count;
    logic       wait_expire;
    logic       fail;
    logic       retransmit;
    logic       emit_init;
    logic       emit_step;
    logic       push;
    logic [1:0] push_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       busy;
    logic       in_wait;
    logic       in_backoff;
    logic       len_ok;
    logic       seq_match;
    logic       wait_expired;
    logic       backoff_expired;
    logic       retries_done;
    logic       store_full;
    logic       emit_last;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/sawarq_stream_if.sv */
`default_nettype none

interface sawarq_req_if import sawarq_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sawarq_res_if import sawarq_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/sawarq_ctrl.sv */
`default_nettype none

module sawarq_ctrl import sawarq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  output logic         req_ready_o,
  input  wire logic    res_free_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_STATUS = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    cmd_o       = '0;
    req_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (status_i.req_type)
          REQ_LOAD: begin
            cmd_o.store_wr = !status_i.busy && !status_i.store_full;
          end
          REQ_SEND: begin
            if (status_i.busy || !status_i.len_ok) begin
              kind_d  = KIND_REJECTED;
              state_d = S_STATUS;
            end else begin
              cmd_o.start_send = 1'b1;
              cmd_o.emit_init  = 1'b1;
              state_d          = S_EMIT;
            end
          end
          REQ_ACK: begin
            if (status_i.in_wait && status_i.seq_match) begin
              cmd_o.ack_done = 1'b1;
              kind_d         = KIND_DELIVERED;
              state_d        = S_STATUS;
            end
          end
          REQ_TICK: begin
            if (status_i.in_wait) begin
              if (!status_i.wait_expired) begin
                cmd_o.tick_count = 1'b1;
              end else if (status_i.retries_done) begin
                cmd_o.fail = 1'b1;
                kind_d     = KIND_FAILED;
                state_d    = S_STATUS;
              end else begin
                cmd_o.wait_expire = 1'b1;
              end
            end else if (status_i.in_backoff) begin
              if (status_i.backoff_expired) begin
                cmd_o.retransmit = 1'b1;
                cmd_o.emit_init  = 1'b1;
                state_d          = S_EMIT;
              end else begin
                cmd_o.tick_count = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_STATUS: begin
        if (res_free_i) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = kind_q;
          state_d         = S_IDLE;
        end
      end
      S_EMIT: begin
        if (res_free_i) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_FRAME;
          cmd_o.emit_step = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_REJECTED;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sawarq_dp.sv */
`default_nettype none

module sawarq_dp import sawarq_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0]    cfg_wdata_i,
  input  wire req_item_t            req_item_i,
  input  wire cmd_t                 cmd_i,
  output status_t                   status_o,
  output res_item_t                 res_item_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 4);

  // configuration
  logic [15:0] ack_timeout_q, backoff_base_q, backoff_max_q;
  logic [3:0]  max_retries_q;

  // protocol state
  req_item_t   item_q;
  logic [1:0]  phase_q;
  logic [CW-1:0] load_cnt_q;
  logic [7:0]  cur_seq_q;
  logic [CW-1:0] cur_len_q;
  logic [3:0]  attempt_q;
  logic [15:0] elapsed_q;
  logic [15:0] backoff_q;
  logic [31:0] sent_q, acked_q, failed_q, retries_q;

  // frame walk
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] rd_off;
  logic          rd_en;
  logic [7:0]    payload_mem_q [MAX_PAYLOAD];
  logic [7:0]    rdata_q;

  logic [16:0] elapsed_inc;
  logic [16:0] backoff_dbl;
  logic [7:0]  frame_byte;

  assign elapsed_inc = {1'b0, elapsed_q} + 17'd1;
  assign backoff_dbl = {backoff_q, 1'b0};

  assign status_o.req_type        = item_q.req_type;
  assign status_o.in_wait         = (phase_q == PH_WAIT);
  assign status_o.in_backoff      = (phase_q == PH_BACKOFF);
  assign status_o.busy            = status_o.in_wait || status_o.in_backoff;
  assign status_o.len_ok          = (item_q.send_len <= 8'(MAX_PAYLOAD)) &&
                                    (item_q.send_len <= 8'(load_cnt_q));
  assign status_o.seq_match       = (item_q.seq == cur_seq_q);
  assign status_o.wait_expired    = (elapsed_inc >= {1'b0, ack_timeout_q});
  assign status_o.backoff_expired = (elapsed_inc >= {1'b0, backoff_q});
  assign status_o.retries_done    = (attempt_q >= max_retries_q);
  assign status_o.store_full      = (load_cnt_q == CW'(MAX_PAYLOAD));
  assign status_o.emit_last       = (pos_q == PW'(cur_len_q) + PW'(2));

  // read one position ahead so the registered byte lines up with pos_q
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.emit_init) begin
      pos_d = '0;
    end else if (cmd_i.emit_step) begin
      pos_d = pos_q + PW'(1);
    end
  end

  assign rd_off = pos_d - PW'(3);
  assign rd_en  = (pos_d >= PW'(3)) && (rd_off < PW'(MAX_PAYLOAD));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= payload_mem_q[rd_off[AW-1:0]];
    end
    if (cmd_i.store_wr) begin
      payload_mem_q[load_cnt_q[AW-1:0]] <= item_q.data_byte;
    end
    if (cmd_i.capture) begin
      item_q <= req_item_i;
    end
  end

  always_comb begin
    if (pos_q == PW'(0)) begin
      frame_byte = DATA_TYPE;
    end else if (pos_q == PW'(1)) begin
      frame_byte = cur_seq_q;
    end else if (pos_q == PW'(2)) begin
      frame_byte = 8'(cur_len_q);
    end else begin
      frame_byte = rdata_q;
    end
  end

  assign res_item_o.kind         = cmd_i.push_kind;
  assign res_item_o.frame_byte   = (cmd_i.push_kind == KIND_FRAME) ? frame_byte : 8'd0;
  assign res_item_o.last         = (cmd_i.push_kind == KIND_FRAME) ? status_o.emit_last : 1'b1;
  assign res_item_o.attempt      = (cmd_i.push_kind == KIND_REJECTED) ? 4'd0 : attempt_q;
  assign res_item_o.sent_count   = sent_q;
  assign res_item_o.acked_count  = acked_q;
  assign res_item_o.failed_count = failed_q;
  assign res_item_o.retry_count  = retries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q  <= ACK_TIMEOUT_RST;
      backoff_base_q <= BACKOFF_BASE_RST;
      backoff_max_q  <= BACKOFF_MAX_RST;
      max_retries_q  <= MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_wdata_i;
        CFG_BACKOFF_BASE: backoff_base_q <= cfg_wdata_i;
        CFG_BACKOFF_MAX:  backoff_max_q  <= cfg_wdata_i;
        CFG_MAX_RETRIES:  max_retries_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      load_cnt_q <= '0;
      cur_seq_q  <= '0;
      cur_len_q  <= '0;
      attempt_q  <= '0;
      elapsed_q  <= '0;
      backoff_q  <= '0;
      sent_q     <= '0;
      acked_q    <= '0;
      failed_q   <= '0;
      retries_q  <= '0;
      pos_q      <= '0;
    end else begin
      pos_q <= pos_d;
      if (cmd_i.store_wr) begin
        load_cnt_q <= load_cnt_q + CW'(1);
      end
      if (cmd_i.start_send) begin
        sent_q     <= sent_q + 32'd1;
        cur_seq_q  <= item_q.seq;
        cur_len_q  <= item_q.send_len[CW-1:0];
        load_cnt_q <= '0;
        attempt_q  <= '0;
        elapsed_q  <= '0;
        backoff_q  <= backoff_base_q;
        phase_q    <= PH_WAIT;
      end
      if (cmd_i.ack_done) begin
        acked_q <= acked_q + 32'd1;
        phase_q <= PH_IDLE;
      end
      if (cmd_i.tick_count) begin
        elapsed_q <= elapsed_inc[15:0];
      end
      if (cmd_i.wait_expire) begin
        elapsed_q <= '0;
        phase_q   <= PH_BACKOFF;
      end
      if (cmd_i.fail) begin
        elapsed_q <= '0;
        failed_q  <= failed_q + 32'd1;
        phase_q   <= PH_IDLE;
      end
      if (cmd_i.retransmit) begin
        elapsed_q <= '0;
        attempt_q <= attempt_q + 4'd1;
        retries_q <= retries_q + 32'd1;
        backoff_q <= (backoff_dbl < {1'b0, backoff_max_q}) ? backoff_dbl[15:0]
                                                            : backoff_max_q;
        phase_q   <= PH_WAIT;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stop_and_wait_arq_sender_unit.sv */
// stop-and-wait arq sender with exponential backoff
// req_i takes one transaction at a time: load a payload byte, a send request,
//   a received acknowledgement or a one millisecond tick
// res_o gives frame bytes (type, seq, length, payload, last marked) and
//   status items (delivered, failed, rejected), each with the four totals
// cfg_we_i/cfg_idx_i/cfg_wdata_i write the timeout, backoff and retry registers
// a transaction is taken in the idle state and decoded in the exec state, which
//   ends it or goes on to push a status item or to walk a frame
// a frame of len payload bytes is len + 3 bytes long: the payload store has
//   one registered read port and the frame walks it one byte per cycle
// the input is not taken again until the last result of the item has gone
//   into the output register, which holds one result for the receiver
// when the receiver stalls, the walk and the sequencer simply hold
// reset: config back to defaults, totals and load count cleared, phase idle;
//   the store is not cleared, only bytes loaded since the last send are read
`default_nettype none
`include "stop_and_wait_arq_sender_unit_defines.svh"

module stop_and_wait_arq_sender_unit import sawarq_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0]    cfg_wdata_i,
  sawarq_req_if.sink                req_i,
  sawarq_res_if.source              res_o
);

  cmd_t      cmd;
  status_t   status;
  res_item_t res_item;
  logic      res_free;

  // output register
  logic      res_valid_q;
  res_item_t res_item_q;

  assign res_free = !res_valid_q || res_o.ready;

  // sequencer: decode, then status item or frame walk
  sawarq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_free_i  (res_free),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // protocol state, timers, totals and the payload store
  sawarq_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_item_i  (req_i.payload),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_item_o  (res_item)
  );

  // a result is only pushed when the register is empty or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd.push) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      res_item_q <= res_item;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_item_q;

  // a push must never overwrite a result the receiver has not taken
  `SAWARQ_ASSERT(a_push_into_free, cmd.push |-> res_free)
  // the sequencer does not produce results while it is open for input
  `SAWARQ_ASSERT_NEVER(a_push_while_ready, cmd.push && req_i.ready)
  // every accepted transaction is decoded before the next one is taken
  `SAWARQ_ASSERT(a_one_at_a_time, (req_i.valid && req_i.ready) |=> !req_i.ready)

endmodule

`default_nettype wire

/* verif/arq_sender_checker.sv */
`timescale 1ns / 1ps

// watches the config port and both channels, keeps its own copy of the sender
// and compares every result transaction with the oldest predicted one
module arq_sender_checker import sawarq_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  req_item_t            req_item_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  res_item_t            res_item_i,
  output int                   error_count_o,
  output int                   pending_o
);

  // shadow registers
  logic [15:0] ack_timeout;
  logic [15:0] backoff_base;
  logic [15:0] backoff_max;
  logic [3:0]  retry_limit;

  // shadow sender state
  logic [7:0]  payload_copy [MAX_PAYLOAD];
  logic [5:0]  load_cnt;
  logic [1:0]  arq_phase;
  logic [7:0]  cur_seq;
  logic [5:0]  cur_len;
  logic [3:0]  attempt_no;
  logic [15:0] elapsed;
  logic [15:0] cur_backoff;
  logic [31:0] sent_total;
  logic [31:0] acked_total;
  logic [31:0] failed_total;
  logic [31:0] retry_total;

  res_item_t outgoing_items [$];
  int        mismatches;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_item(input logic [1:0] kind, input logic [7:0] fbyte,
                            input logic last);
    res_item_t it;
    it.kind         = kind;
    it.frame_byte   = fbyte;
    it.last         = last;
    it.attempt      = (kind == KIND_REJECTED) ? 4'd0 : attempt_no;
    it.sent_count   = sent_total;
    it.acked_count  = acked_total;
    it.failed_count = failed_total;
    it.retry_count  = retry_total;
    outgoing_items.push_back(it);
  endtask

  // type byte, seq, length, then the payload with the last byte marked
  task automatic queue_frame();
    queue_item(KIND_FRAME, DATA_TYPE, 1'b0);
    queue_item(KIND_FRAME, cur_seq, 1'b0);
    queue_item(KIND_FRAME, {2'b00, cur_len}, cur_len == 6'd0);
    for (int i = 0; i < cur_len; i++)
      queue_item(KIND_FRAME, payload_copy[i], i + 1 == cur_len);
  endtask

  task automatic advance_sender(input req_item_t it);
    logic        busy;
    logic [16:0] doubled;
    busy = (arq_phase == PH_WAIT) || (arq_phase == PH_BACKOFF);
    case (it.req_type)
      REQ_LOAD: begin
        // loads are dropped while busy or once the store is full
        if (!busy && load_cnt < MAX_PAYLOAD) begin
          payload_copy[load_cnt] = it.data_byte;
          load_cnt++;
        end
      end
      REQ_SEND: begin
        if (busy || it.send_len > MAX_PAYLOAD || it.send_len > load_cnt) begin
          queue_item(KIND_REJECTED, 8'h00, 1'b1);
        end else begin
          sent_total++;
          cur_seq     = it.seq;
          cur_len     = it.send_len[5:0];
          load_cnt    = '0;
          attempt_no  = '0;
          elapsed     = '0;
          cur_backoff = backoff_base;
          arq_phase   = PH_WAIT;
          queue_frame();
        end
      end
      REQ_ACK: begin
        // stray acks (wrong seq, idle, backoff) change nothing
        if (arq_phase == PH_WAIT && it.seq == cur_seq) begin
          acked_total++;
          arq_phase = PH_IDLE;
          queue_item(KIND_DELIVERED, 8'h00, 1'b1);
        end
      end
      default: begin
        // tick: count first, then compare, so a zero limit behaves as one
        if (arq_phase == PH_WAIT) begin
          elapsed++;
          if (elapsed >= ack_timeout) begin
            elapsed = '0;
            if (attempt_no >= retry_limit) begin
              failed_total++;
              arq_phase = PH_IDLE;
              queue_item(KIND_FAILED, 8'h00, 1'b1);
            end else begin
              arq_phase = PH_BACKOFF;
            end
          end
        end else if (arq_phase == PH_BACKOFF) begin
          elapsed++;
          if (elapsed >= cur_backoff) begin
            doubled     = {cur_backoff, 1'b0};
            elapsed     = '0;
            attempt_no++;
            retry_total++;
            cur_backoff = (doubled < {1'b0, backoff_max}) ? doubled[15:0] : backoff_max;
            arq_phase   = PH_WAIT;
            queue_frame();
          end
        end
      end
    endcase
  endtask

  task automatic check_outgoing(input res_item_t got);
    res_item_t want;
    if (outgoing_items.size() == 0) begin
      note_mismatch("result with nothing expected", {30'd0, got.kind}, 32'd0);
    end else begin
      want = outgoing_items.pop_front();
      if (got.kind != want.kind)
        note_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.frame_byte != want.frame_byte)
        note_mismatch("frame_byte", 32'(got.frame_byte), 32'(want.frame_byte));
      if (got.last != want.last)
        note_mismatch("last", 32'(got.last), 32'(want.last));
      if (got.attempt != want.attempt)
        note_mismatch("attempt", 32'(got.attempt), 32'(want.attempt));
      if (got.sent_count != want.sent_count) note_mismatch("sent_count", got.sent_count,
                                                           want.sent_count);
      if (got.acked_count != want.acked_count)
        note_mismatch("acked_count", got.acked_count, want.acked_count);
      if (got.failed_count != want.failed_count)
        note_mismatch("failed_count", got.failed_count, want.failed_count);
      if (got.retry_count != want.retry_count)
        note_mismatch("retry_count", got.retry_count, want.retry_count);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout   = ACK_TIMEOUT_RST;
      backoff_base  = BACKOFF_BASE_RST;
      backoff_max   = BACKOFF_MAX_RST;
      retry_limit   = MAX_RETRIES_RST;
      load_cnt      = '0;
      arq_phase     = PH_IDLE;
      cur_seq       = '0;
      cur_len       = '0;
      attempt_no    = '0;
      elapsed       = '0;
      cur_backoff   = '0;
      sent_total    = '0;
      acked_total   = '0;
      failed_total  = '0;
      retry_total   = '0;
      mismatches    = 0;
      outgoing_items.delete();
    end else begin
      if (res_valid_i && res_ready_i) check_outgoing(res_item_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACK_TIMEOUT:  ack_timeout  = cfg_wdata_i;
          CFG_BACKOFF_BASE: backoff_base = cfg_wdata_i;
          CFG_BACKOFF_MAX:  backoff_max  = cfg_wdata_i;
          default:          retry_limit  = cfg_wdata_i[3:0];
        endcase
      end
      if (req_valid_i && req_ready_i) advance_sender(req_item_i);
    end
    pending_o     <= outgoing_items.size();
    error_count_o <= mismatches;
  end

endmodule

/* verif/stop_and_wait_arq_sender_unit_tb.sv */
`timescale 1ns / 1ps

// stimulus and verdict for the stop-and-wait arq sender
// a short directed run at reset defaults and with a tiny retry budget, then
// phases of random exchanges (load, send, ticks and acks until the send is
// delivered or fails) under several register settings, extremes among them
module stop_and_wait_arq_sender_unit_tb;
  import sawarq_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int          DRAIN_CYCLES = 8;   // covers a transaction with no result

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;
  logic                 req_valid = 1'b0;
  req_item_t            req_item  = '0;
  logic                 res_ready = 1'b0;

  int          fail_cnt;
  int          pending_cnt;
  int          closed_cnt = 0;   // delivered and failed transactions seen
  logic [7:0]  stall_cycle = '0;

  // stimulus bookkeeping
  int items_done;
  int burst_left;
  int ack_pct;
  int loaded;
  bit gaps_on;

  sawarq_req_if req_ch ();
  sawarq_res_if res_ch ();

  assign req_ch.valid   = req_valid;
  assign req_ch.payload = req_item;
  assign res_ch.ready   = res_ready;

  stop_and_wait_arq_sender_unit #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  arq_sender_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .req_valid_i   (req_ch.valid),
    .req_ready_i   (req_ch.ready),
    .req_item_i    (req_ch.payload),
    .res_valid_i   (res_ch.valid),
    .res_ready_i   (res_ch.ready),
    .res_item_i    (res_ch.payload),
    .error_count_o (fail_cnt),
    .pending_o     (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: always ready, random stalls, ready one cycle in four, rare stalls
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 8'd1;
    case (stall_cycle[7:6])
      2'd0:    res_ready <= 1'b1;
      2'd1:    res_ready <= ($urandom_range(0, 99) < 60);
      2'd2:    res_ready <= (stall_cycle[1:0] == 2'b11);
      default: res_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // a send is closed by a delivered or failed transaction
  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready &&
        (res_ch.payload.kind == KIND_DELIVERED || res_ch.payload.kind == KIND_FAILED))
      closed_cnt <= closed_cnt + 1;
  end

  function automatic req_item_t req_of(input logic [1:0] rt, input logic [7:0] dbyte,
                                       input logic [7:0] sq, input logic [7:0] len);
    req_item_t it;
    it.req_type  = rt;
    it.data_byte = dbyte;
    it.seq       = sq;
    it.send_len  = len;
    return it;
  endfunction

  // one transaction on the request channel, with burst gaps when enabled
  task automatic send_req(input req_item_t it);
    if (gaps_on && burst_left <= 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    burst_left--;
    items_done++;
  endtask

  // hold off until every predicted result has gone, then let the block settle
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [15:0] timeout, input logic [15:0] base,
                               input logic [15:0] cap, input logic [3:0] retries);
    settle();
    cfg_we <= 1'b1; cfg_idx <= CFG_ACK_TIMEOUT;  cfg_wdata <= timeout; @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CFG_BACKOFF_BASE; cfg_wdata <= base;    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CFG_BACKOFF_MAX;  cfg_wdata <= cap;     @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CFG_MAX_RETRIES;  cfg_wdata <= {12'd0, retries};
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // load some bytes, send, then unless rejected ticks and acks until the send is closed
  task automatic run_exchange();
    int         k;
    int         r;
    int         opened;
    logic [7:0] sq;
    logic [7:0] len;
    r = $urandom_range(0, 99);
    if (r < 10)      k = MAX_PAYLOAD - loaded + $urandom_range(1, 2);  // overfill
    else if (r < 80) k = $urandom_range(0, 3);
    else             k = $urandom_range(0, MAX_PAYLOAD - loaded);
    for (int i = 0; i < k; i++) begin
      send_req(req_of(REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom)));
      if (loaded < MAX_PAYLOAD) loaded++;
    end
    sq = 8'($urandom);
    // bad length: rejected, load count kept
    if ($urandom_range(0, 9) == 0) begin
      len = 8'($urandom_range(loaded + 1, 255));
      send_req(req_of(REQ_SEND, 8'($urandom), sq, len));
      return;
    end
    len    = 8'($urandom_range(0, loaded));
    loaded = 0;
    opened = closed_cnt;
    send_req(req_of(REQ_SEND, 8'($urandom), sq, len));
    // still waiting here, so both of these are turned away
    if ($urandom_range(0, 5) == 0)
      send_req(req_of(REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom)));
    if ($urandom_range(0, 5) == 0)
      send_req(req_of(REQ_SEND, 8'($urandom), 8'($urandom), 8'($urandom)));
    while (closed_cnt == opened) begin
      r = $urandom_range(0, 99);
      if (r < ack_pct)
        send_req(req_of(REQ_ACK, 8'($urandom), sq, 8'($urandom)));
      else if (r < ack_pct + 8)
        send_req(req_of(REQ_ACK, 8'($urandom), sq ^ 8'($urandom_range(1, 255)),
                        8'($urandom)));
      else
        send_req(req_of(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom)));
    end
  endtask

  task automatic run_phase(input logic [15:0] timeout, input logic [15:0] base,
                           input logic [15:0] cap, input logic [3:0] retries,
                           input int ack_share, input bit with_gaps, input int budget);
    load_settings(timeout, base, cap, retries);
    ack_pct    = ack_share;
    gaps_on    = with_gaps;
    items_done = 0;
    while (items_done < budget) begin
      run_exchange();
      if ($urandom_range(0, 4) == 0) settle();
    end
  endtask

  initial begin
    items_done = 0;
    burst_left = 0;
    loaded     = 0;
    gaps_on    = 1'b1;
    ack_pct    = 10;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    send_req(req_of(REQ_TICK, 8'h00, 8'h00, 8'h00));  // tick while idle
    send_req(req_of(REQ_ACK,  8'h00, 8'h00, 8'h00));  // ack while idle
    send_req(req_of(REQ_SEND, 8'h00, 8'h00, 8'h00));  // empty frame, last on length
    send_req(req_of(REQ_LOAD, 8'hAA, 8'h00, 8'h00));  // load while busy
    send_req(req_of(REQ_SEND, 8'h00, 8'h11, 8'h00));  // send while busy
    send_req(req_of(REQ_ACK,  8'h00, 8'h01, 8'h00));  // wrong seq
    send_req(req_of(REQ_TICK, 8'h00, 8'h00, 8'h00));
    send_req(req_of(REQ_ACK,  8'h00, 8'h00, 8'h00));  // delivered
    send_req(req_of(REQ_SEND, 8'h00, 8'h22, 8'hFF));  // length above maximum
    send_req(req_of(REQ_LOAD, 8'h00, 8'h00, 8'h00));
    send_req(req_of(REQ_LOAD, 8'hFF, 8'hFF, 8'hFF));
    send_req(req_of(REQ_SEND, 8'h00, 8'h33, 8'h03));  // length above load count
    send_req(req_of(REQ_SEND, 8'h00, 8'hFF, 8'h02));
    send_req(req_of(REQ_ACK,  8'h00, 8'hFF, 8'h00));  // delivered

    // directed, first backoff above the cap and one retry allowed
    load_settings(16'd1, 16'd2, 16'd1, 4'd1);
    send_req(req_of(REQ_LOAD, 8'h5A, 8'h00, 8'h00));
    send_req(req_of(REQ_SEND, 8'h00, 8'h80, 8'h01));
    send_req(req_of(REQ_TICK, 8'h00, 8'h00, 8'h00));  // timeout, into backoff
    send_req(req_of(REQ_ACK,  8'h00, 8'h80, 8'h00));  // ack during backoff
    send_req(req_of(REQ_TICK, 8'h00, 8'h00, 8'h00));
    send_req(req_of(REQ_TICK, 8'h00, 8'h00, 8'h00));  // retransmission
    send_req(req_of(REQ_TICK, 8'h00, 8'h00, 8'h00));  // retries spent, failed
    send_req(req_of(REQ_ACK,  8'h00, 8'h80, 8'h00));  // too late
    loaded = 0;

    // random phases
    run_phase(16'd1, 16'd1, 16'd1, 4'd0, 10, 1'b1, 8);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 25, 1'b1, 8);
    run_phase(16'd3, 16'd5, 16'd2, 4'd4, 15, 1'b0, 8);
    run_phase(16'd2, 16'd1, 16'hFFFF, 4'd5, 15, 1'b1, 8);
    run_phase(16'd1, 16'd1, 16'd2, 4'd15, 15, 1'b1, 8);
    run_phase(16'd0, 16'd0, 16'd0, 4'd2, 15, 1'b1, 8);  // zero limits act as one
    run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
              16'($urandom_range(1, 12)), 4'($urandom_range(0, 15)), 20, 1'b1, 8);
    run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
              16'($urandom_range(1, 12)), 4'($urandom_range(0, 15)), 20, 1'b0, 8);

    settle();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("stop_and_wait_arq_sender_unit test passed");
    end else begin
      $display("stop_and_wait_arq_sender_unit test failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #20000000;
    $display("stop_and_wait_arq_sender_unit test failed");
    $finish;
  end

endmodule
